/* hdl/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants for the serial command frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned ELAPSED_W  = TIMEOUT_W + 1;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = TIMEOUT_W;

  // byte positions after the delimiter: command is 1, ID 2..5, value 6..9
  localparam logic [COUNT_W-1:0] VALUE_FIRST_INDEX = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] FRAME_LAST_INDEX  = COUNT_W'(9);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam logic [BYTE_W-1:0]    START_BYTE_RST = 8'h00;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_TIMEOUT_MS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_DONE    = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CMD   = 2'd1,
    PH_ID    = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

endpackage

/* hdl/serial_command_frame_receiver.sv */
// The result is registered and valid in the cycle after its word is accepted.
// Throughput: one word per cycle while out_ready; one result per accepted word.
// The single output register decouples the sides: in_ready is high whenever it
// is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): frame state idle, start byte 0, timeout 1000.
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// Hunts a byte/tick stream for a start delimiter, collects command, ID and
// value bytes, and reports completed frames or timeout aborts.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scfr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [scfr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [scfr_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scfr_pkg::EVENT_W-1:0]        out_event_res,
  output logic [scfr_pkg::BYTE_W-1:0]         out_command,
  output logic [scfr_pkg::WORD_W-1:0]         out_target_id,
  output logic [scfr_pkg::WORD_W-1:0]         out_set_value
);
  import scfr_pkg::*;

  logic [BYTE_W-1:0]    start_byte_r;
  logic [TIMEOUT_W-1:0] timeout_ms_r;

  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [BYTE_W-1:0]    cmd_r, cmd_nxt;
  logic [WORD_W-1:0]    id_r, id_nxt;
  logic [WORD_W-1:0]    val_r, val_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;

  logic                 out_valid_r;
  event_t               ev_r, ev_nxt;
  logic [BYTE_W-1:0]    ocmd_r, ocmd_nxt;
  logic [WORD_W-1:0]    oid_r, oid_nxt;
  logic [WORD_W-1:0]    oval_r, oval_nxt;

  logic                 in_acc;
  logic [COUNT_W-1:0]   count_inc;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [WORD_W-1:0]    val_shifted;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign count_inc = count_r + COUNT_W'(1);
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r
                                                  : elapsed_r + ELAPSED_W'(1);
  assign val_shifted = {in_rx_byte, val_r[WORD_W-1:BYTE_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      timeout_ms_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_START_BYTE: start_byte_r <= cfg_wdata[BYTE_W-1:0];
        CFG_TIMEOUT_MS: timeout_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    val_nxt     = val_r;
    elapsed_nxt = elapsed_r;
    ev_nxt      = EV_NONE;
    ocmd_nxt    = '0;
    oid_nxt     = '0;
    oval_nxt    = '0;

    if (req_t'(in_req_type) == REQ_TICK) begin
      if (phase_r != PH_IDLE) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {1'b0, timeout_ms_r}) begin
          phase_nxt   = PH_IDLE;
          count_nxt   = '0;
          cmd_nxt     = '0;
          id_nxt      = '0;
          val_nxt     = '0;
          elapsed_nxt = '0;
          ev_nxt      = EV_TIMEOUT;
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == start_byte_r) begin
            phase_nxt   = PH_CMD;
            count_nxt   = '0;
            cmd_nxt     = '0;
            id_nxt      = '0;
            val_nxt     = '0;
            elapsed_nxt = '0;
          end
        end
        PH_CMD: begin
          count_nxt = count_inc;
          cmd_nxt   = in_rx_byte;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          count_nxt = count_inc;
          id_nxt    = {in_rx_byte, id_r[WORD_W-1:BYTE_W]};
          if (count_inc >= VALUE_FIRST_INDEX - COUNT_W'(1)) begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          count_nxt = count_inc;
          val_nxt   = val_shifted;
          if (count_inc >= FRAME_LAST_INDEX) begin
            ev_nxt      = EV_DONE;
            ocmd_nxt    = cmd_r;
            oid_nxt     = id_r;
            oval_nxt    = val_shifted;
            phase_nxt   = PH_IDLE;
            count_nxt   = '0;
            cmd_nxt     = '0;
            id_nxt      = '0;
            val_nxt     = '0;
            elapsed_nxt = '0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      cmd_r       <= '0;
      id_r        <= '0;
      val_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r   <= phase_nxt;
        count_r   <= count_nxt;
        cmd_r     <= cmd_nxt;
        id_r      <= id_nxt;
        val_r     <= val_nxt;
        elapsed_r <= elapsed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r   <= ev_nxt;
      ocmd_r <= ocmd_nxt;
      oid_r  <= oid_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_command   = ocmd_r;
  assign out_target_id = oid_r;
  assign out_set_value = oval_r;

endmodule

/* hdl/scfr_checker.sv */
// ----------------------------------------------------------------------------
// scfr_port_checks
// Port-level checks for the serial command frame receiver.
// ----------------------------------------------------------------------------
module scfr_port_checks (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [scfr_pkg::EVENT_W-1:0]   out_event_res,
  input logic [scfr_pkg::BYTE_W-1:0]    out_command,
  input logic [scfr_pkg::WORD_W-1:0]    out_target_id,
  input logic [scfr_pkg::WORD_W-1:0]    out_set_value
);
  import scfr_pkg::*;

  // every accepted word produces a result word next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
      $stable(out_command) && $stable(out_target_id) && $stable(out_set_value))
    else $error("stalled result changed");

  // no new word while the result slot is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

  // payload is zero unless a frame completed
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_DONE) |->
      out_command == '0 && out_target_id == '0 && out_set_value == '0)
    else $error("nonzero payload on non-frame event");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res == EV_NONE || out_event_res == EV_DONE ||
      out_event_res == EV_TIMEOUT)
    else $error("illegal event code");

endmodule

bind serial_command_frame_receiver scfr_port_checks u_scfr_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .out_command   (out_command),
  .out_target_id (out_target_id),
  .out_set_value (out_set_value)
);
